// ===== design/rnf_pkg.sv =====
`timescale 1ns / 1ps

package rnf_pkg;

    localparam int OUT_LIMIT_DEF = 32;
    localparam int MAX_RESULTS   = 32;

    localparam int VAL_W   = 32;
    localparam int RADIX_W = 5;
    localparam int FW_W    = 6;
    localparam int CNT_W   = 6;
    localparam int CHAR_W  = 8;
    localparam int DIG_W   = 4;

    localparam int QDEPTH        = 2;
    localparam int BITS_PER_STEP = 8;
    localparam int STEPS         = VAL_W / BITS_PER_STEP;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [RADIX_W-1:0] radix;
        logic [FW_W-1:0]    width;
        logic [CNT_W-1:0]   count;
        logic [CHAR_W-1:0]  lead;
        logic [CHAR_W-1:0]  tail;
    } t_job;

    // lower-case digit set "0123456789abcdef"
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d < DIG_W'(10)) begin
            return CHAR_W'(8'h30) + ext;
        end else begin
            return CHAR_W'(8'h57) + ext;
        end
    endfunction

endpackage

// ===== design/rnf_front.sv =====
`timescale 1ns / 1ps

module rnf_front #(
    parameter int OUT_LIMIT = rnf_pkg::OUT_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rnf_pkg::VAL_W-1:0]        i_value,
    input  logic [rnf_pkg::RADIX_W-1:0]      i_radix,
    input  logic [rnf_pkg::FW_W-1:0]         i_field_width,
    input  logic [rnf_pkg::CNT_W-1:0]        i_char_count,
    input  logic [rnf_pkg::CHAR_W-1:0]       i_lead_pad,
    input  logic [rnf_pkg::CHAR_W-1:0]       i_tail_pad,
    input  logic                             i_q_full,
    output logic                             o_push,
    output rnf_pkg::t_job                    o_job
);

    localparam int CNT_CAP = (OUT_LIMIT > rnf_pkg::MAX_RESULTS) ?
                             rnf_pkg::MAX_RESULTS : OUT_LIMIT;
    localparam logic [rnf_pkg::CNT_W-1:0] CAP = rnf_pkg::CNT_W'(CNT_CAP);

    logic [rnf_pkg::RADIX_W-1:0] radix_c;
    logic [rnf_pkg::CNT_W-1:0]   count_c;
    logic                        accept;

    always_comb begin
        if (i_radix < rnf_pkg::RADIX_MIN) begin
            radix_c = rnf_pkg::RADIX_MIN;
        end else if (i_radix > rnf_pkg::RADIX_MAX) begin
            radix_c = rnf_pkg::RADIX_MAX;
        end else begin
            radix_c = i_radix;
        end
        count_c = (i_char_count > CAP) ? CAP : i_char_count;
    end

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    // zero-length words produce nothing and are dropped here
    assign o_push  = accept && (count_c != '0);

    assign o_job.value = i_value;
    assign o_job.radix = radix_c;
    assign o_job.width = i_field_width;
    assign o_job.count = count_c;
    assign o_job.lead  = i_lead_pad;
    assign o_job.tail  = i_tail_pad;

`ifndef NO_ASSERTIONS
    a_push_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.count != '0 && o_job.count <= CAP))
        else $error("front pushed bad count");
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.radix >= rnf_pkg::RADIX_MIN && o_job.radix <= rnf_pkg::RADIX_MAX))
        else $error("front pushed bad radix");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("push into full queue");
`endif

endmodule

// ===== design/rnf_queue.sv =====
`timescale 1ns / 1ps

module rnf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rnf_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rnf_pkg::t_job  o_data,
    output logic           o_empty
);

    localparam int PTR_W = (rnf_pkg::QDEPTH > 1) ? $clog2(rnf_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(rnf_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(rnf_pkg::QDEPTH);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(rnf_pkg::QDEPTH - 1);

    rnf_pkg::t_job    r_mem [rnf_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/rnf_back.sv =====
`timescale 1ns / 1ps

module rnf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  rnf_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rnf_pkg::CHAR_W-1:0]   o_out_char,
    output logic                         o_last
);

    localparam int VW   = rnf_pkg::VAL_W;
    localparam int BPS  = rnf_pkg::BITS_PER_STEP;
    localparam int CW   = rnf_pkg::CNT_W;
    localparam int DW   = rnf_pkg::DIG_W;
    localparam int RW   = rnf_pkg::RADIX_W;
    localparam int IDXW = $clog2(rnf_pkg::MAX_RESULTS);
    localparam int PH_W = (rnf_pkg::STEPS > 1) ? $clog2(rnf_pkg::STEPS) : 1;
    localparam logic [PH_W-1:0] PH_LAST  = PH_W'(rnf_pkg::STEPS - 1);
    localparam logic [CW-1:0]   DIG_LAST = CW'(VW - 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PREP, S_EMIT} t_state;

    t_state                    r_state, n_state;
    logic [VW-1:0]             r_val, n_val;
    logic [DW-1:0]             r_rem, n_rem;
    logic [PH_W-1:0]           r_phase, n_phase;
    logic [RW-1:0]             r_radix, n_radix;
    logic [rnf_pkg::FW_W-1:0]  r_width, n_width;
    logic [CW-1:0]             r_count, n_count;
    logic [rnf_pkg::CHAR_W-1:0] r_lead, n_lead;
    logic [rnf_pkg::CHAR_W-1:0] r_tail, n_tail;
    logic [CW-1:0]             r_ndig, n_ndig;
    logic [DW-1:0]             r_digs [rnf_pkg::MAX_RESULTS];
    logic [CW-1:0]             r_lead_n, n_lead_n;
    logic [CW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_next, n_next;
    logic                      r_out_valid, n_out_valid;
    logic [rnf_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic                      r_out_last, n_out_last;

    logic                      dig_we;
    logic [DW-1:0]             step_rem;
    logic [BPS-1:0]            step_q;
    logic [VW-1:0]             quot;
    logic                      can_load;
    logic                      load_last;

    // one byte of restoring long division per cycle
    always_comb begin
        logic [DW:0]   t;
        logic [DW-1:0] rem;
        rem    = r_rem;
        step_q = '0;
        for (int k = 0; k < BPS; k++) begin
            t = {rem, r_val[VW-1-k]};
            if (t >= (DW+1)'(r_radix)) begin
                step_q[BPS-1-k] = 1'b1;
                rem = DW'(t - (DW+1)'(r_radix));
            end else begin
                rem = t[DW-1:0];
            end
        end
        step_rem = rem;
    end

    assign quot     = {r_val[VW-BPS-1:0], step_q};
    assign can_load = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_last = (r_state == S_EMIT) && can_load && (r_pos == r_count - CW'(1));

    always_comb begin
        logic [CW-1:0] nm1;
        logic [CW-1:0] diff;
        n_state     = r_state;
        n_val       = r_val;
        n_rem       = r_rem;
        n_phase     = r_phase;
        n_radix     = r_radix;
        n_width     = r_width;
        n_count     = r_count;
        n_lead      = r_lead;
        n_tail      = r_tail;
        n_ndig      = r_ndig;
        n_lead_n    = r_lead_n;
        n_pos       = r_pos;
        n_next      = r_next;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        dig_we      = 1'b0;
        nm1         = r_next - CW'(1);
        diff        = CW'(r_width) - r_ndig;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_val   = i_job.value;
                    n_radix = i_job.radix;
                    n_width = i_job.width;
                    n_count = i_job.count;
                    n_lead  = i_job.lead;
                    n_tail  = i_job.tail;
                    n_rem   = '0;
                    n_phase = '0;
                    n_ndig  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_val   = quot;
                n_rem   = step_rem;
                n_phase = r_phase + PH_W'(1);
                if (r_phase == PH_LAST) begin
                    dig_we  = 1'b1;
                    n_ndig  = r_ndig + CW'(1);
                    n_rem   = '0;
                    n_phase = '0;
                    if (quot == '0 || r_ndig == DIG_LAST) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                if (CW'(r_width) > r_ndig) begin
                    n_lead_n = (diff > r_count) ? r_count : diff;
                end else begin
                    n_lead_n = '0;
                end
                n_next  = r_ndig;
                n_pos   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_pos       = r_pos + CW'(1);
                    if (r_pos < r_lead_n) begin
                        n_out_char = r_lead;
                    end else if (r_next != '0) begin
                        n_out_char = rnf_pkg::digit_char(r_digs[nm1[IDXW-1:0]]);
                        n_next     = nm1;
                    end else begin
                        n_out_char = r_tail;
                    end
                    n_out_last = load_last;
                    if (load_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_rem      <= n_rem;
        r_phase    <= n_phase;
        r_radix    <= n_radix;
        r_width    <= n_width;
        r_count    <= n_count;
        r_lead     <= n_lead;
        r_tail     <= n_tail;
        r_ndig     <= n_ndig;
        r_lead_n   <= n_lead_n;
        r_pos      <= n_pos;
        r_next     <= n_next;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        if (dig_we) begin
            r_digs[r_ndig[IDXW-1:0]] <= step_rem;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_pos < r_count))
        else $error("emit position past count");
    a_ndig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> (r_ndig != '0 && r_ndig <= CW'(VW)))
        else $error("digit count out of range");
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_last |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final word not followed by idle");
`endif

endmodule

// ===== design/radix_number_formatter.sv =====
`timescale 1ns / 1ps

// Formats a 32-bit unsigned value as lower-case ASCII digits in base 2..16
// (out-of-range bases clamp to 2 or 16) and emits exactly char_count words
// (clamped to the output limit, zero gives no words), one character each,
// o_last set on the final one: leading pads for width beyond the digit
// count, then digits most significant first, then trailing pads; low digits
// are dropped when room runs out. The front classifies items into a
// two-entry queue; the back divides one byte of quotient per cycle for each
// digit (up to 32 in base 2), then emits the words, holding them while the
// output side stalls.
module radix_number_formatter #(
    parameter int P_OUT_LIMIT = rnf_pkg::OUT_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rnf_pkg::VAL_W-1:0]     i_value,
    input  logic [rnf_pkg::RADIX_W-1:0]   i_radix,
    input  logic [rnf_pkg::FW_W-1:0]      i_field_width,
    input  logic [rnf_pkg::CNT_W-1:0]     i_char_count,
    input  logic [rnf_pkg::CHAR_W-1:0]    i_lead_pad,
    input  logic [rnf_pkg::CHAR_W-1:0]    i_tail_pad,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rnf_pkg::CHAR_W-1:0]    o_out_char,
    output logic                          o_last
);

    rnf_pkg::t_job push_job;
    rnf_pkg::t_job head_job;
    logic          push;
    logic          q_full;
    logic          q_empty;
    logic          pop;

    rnf_front #(
        .OUT_LIMIT (P_OUT_LIMIT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_field_width (i_field_width),
        .i_char_count  (i_char_count),
        .i_lead_pad    (i_lead_pad),
        .i_tail_pad    (i_tail_pad),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    rnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (q_empty)
    );

    rnf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule
